FILE: sv/qsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsa_pkg
// Shared types and default sizes for the quicksort array sorter.
// ----------------------------------------------------------------------------
package qsa_pkg;

  localparam int DATA_W       = 32;
  localparam int CAPACITY_DEF = 64;

  typedef logic [DATA_W-1:0] word_t;

endpackage

FILE: sv/qsa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsa_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module qsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/quicksort_array_sorter.sv
`timescale 1ns / 1ps
// Loading: one word per cycle while busy is low; the word flagged last starts the sort.
// Sort: each range is popped, its pivot fetched, its words scanned (a word less than the pivot
// is swapped into place), the pivot swapped to its final slot and both sides pushed, all through
// one store port pair and one signed comparator; an already ordered set is the slowest case.
// Emission: the store is read, then N results follow on consecutive cycles that cannot be held off.
// Reset (synchronous, rst_n low) clears state, count, stack pointer, overflow and strobe.
// ----------------------------------------------------------------------------
// quicksort_array_sorter
// Collects signed words into a store, sorts them in place by Lomuto quicksort
// with a range stack, and emits them in ascending order.
// ----------------------------------------------------------------------------
module quicksort_array_sorter
  import qsa_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     in_last,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_sorted_value,
  output logic                     out_final_res,
  output logic                     out_dropped
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = 2 * AW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INIT  = 4'd1;
  localparam logic [3:0] S_POP   = 4'd2;
  localparam logic [3:0] S_POPW  = 4'd3;
  localparam logic [3:0] S_PIV   = 4'd4;
  localparam logic [3:0] S_SCAN  = 4'd5;
  localparam logic [3:0] S_SWAP  = 4'd6;
  localparam logic [3:0] S_SWAP2 = 4'd7;
  localparam logic [3:0] S_FINR  = 4'd8;
  localparam logic [3:0] S_FIN1  = 4'd9;
  localparam logic [3:0] S_FIN2  = 4'd10;
  localparam logic [3:0] S_PUSHR = 4'd11;
  localparam logic [3:0] S_PUSHL = 4'd12;
  localparam logic [3:0] S_EMIT  = 4'd13;

  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);
  localparam logic [CW-1:0] TWO_C = CW'(2);

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] sp_r, sp_nxt;
  logic          ovf_r, ovf_nxt;
  logic          valid_r, valid_nxt;
  logic          final_r, final_nxt;
  logic          drop_r, drop_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] k_r, k_nxt;
  word_t         pivot_r, pivot_nxt;
  word_t         elem_r, elem_nxt;

  logic          st_we, st_re;
  logic [AW-1:0] st_waddr, st_raddr;
  word_t         st_wdata, st_rdata;
  logic          sk_we, sk_re;
  logic [AW-1:0] sk_waddr, sk_raddr;
  logic [SW-1:0] sk_wdata, sk_rdata;

  logic [CW-1:0] p_w;
  logic [CW-1:0] pp1_w;
  logic [CW-1:0] pm1_w;
  logic [CW-1:0] cm1_w;
  logic [CW-1:0] ip1_w;
  logic [CW-1:0] spm1_w;
  logic          less_w;

  assign p_w    = fill_r - ONE_C;
  assign pp1_w  = p_w + ONE_C;
  assign pm1_w  = p_w - ONE_C;
  assign cm1_w  = count_r - ONE_C;
  assign ip1_w  = i_r + ONE_C;
  assign spm1_w = sp_r - ONE_C;
  assign less_w = $signed(st_rdata) < $signed(pivot_r);

  qsa_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (st_we),
    .waddr(st_waddr),
    .wdata(st_wdata),
    .re   (st_re),
    .raddr(st_raddr),
    .rdata(st_rdata)
  );

  qsa_ram #(
    .WIDTH(SW),
    .DEPTH(CAPACITY)
  ) u_stack (
    .clk  (clk),
    .we   (sk_we),
    .waddr(sk_waddr),
    .wdata(sk_wdata),
    .re   (sk_re),
    .raddr(sk_raddr),
    .rdata(sk_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    sp_nxt    = sp_r;
    ovf_nxt   = ovf_r;
    valid_nxt = 1'b0;
    final_nxt = final_r;
    drop_nxt  = drop_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    i_nxt     = i_r;
    fill_nxt  = fill_r;
    k_nxt     = k_r;
    pivot_nxt = pivot_r;
    elem_nxt  = elem_r;
    st_we     = 1'b0;
    st_waddr  = '0;
    st_wdata  = '0;
    st_re     = 1'b0;
    st_raddr  = '0;
    sk_we     = 1'b0;
    sk_waddr  = '0;
    sk_wdata  = '0;
    sk_re     = 1'b0;
    sk_raddr  = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (count_r < CAP_C) begin
            st_we     = 1'b1;
            st_waddr  = count_r[AW-1:0];
            st_wdata  = word_t'(in_value);
            count_nxt = count_r + ONE_C;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        sp_nxt = '0;
        if (count_r >= TWO_C) begin
          sk_we    = 1'b1;
          sk_waddr = '0;
          sk_wdata = {{AW{1'b0}}, cm1_w[AW-1:0]};
          sp_nxt   = ONE_C;
        end
        state_nxt = S_POP;
      end
      S_POP: begin
        if (sp_r == '0) begin
          k_nxt     = '0;
          state_nxt = S_EMIT;
        end else begin
          sk_re     = 1'b1;
          sk_raddr  = spm1_w[AW-1:0];
          sp_nxt    = spm1_w;
          state_nxt = S_POPW;
        end
      end
      S_POPW: begin
        lo_nxt = CW'(sk_rdata[SW-1:AW]);
        hi_nxt = CW'(sk_rdata[AW-1:0]);
        if (CW'(sk_rdata[SW-1:AW]) >= CW'(sk_rdata[AW-1:0])) begin
          state_nxt = S_POP;
        end else begin
          st_re     = 1'b1;
          st_raddr  = sk_rdata[SW-1:AW];
          i_nxt     = CW'(sk_rdata[SW-1:AW]) + ONE_C;
          fill_nxt  = CW'(sk_rdata[SW-1:AW]) + ONE_C;
          state_nxt = S_PIV;
        end
      end
      S_PIV: begin
        pivot_nxt = st_rdata;
        st_re     = 1'b1;
        st_raddr  = i_r[AW-1:0];
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (less_w && (i_r != fill_r)) begin
          elem_nxt  = st_rdata;
          st_re     = 1'b1;
          st_raddr  = fill_r[AW-1:0];
          state_nxt = S_SWAP;
        end else begin
          if (less_w) begin
            fill_nxt = fill_r + ONE_C;
          end
          i_nxt = ip1_w;
          if (i_r == hi_r) begin
            state_nxt = S_FINR;
          end else begin
            st_re    = 1'b1;
            st_raddr = ip1_w[AW-1:0];
          end
        end
      end
      S_SWAP: begin
        st_we     = 1'b1;
        st_waddr  = i_r[AW-1:0];
        st_wdata  = st_rdata;
        state_nxt = S_SWAP2;
      end
      S_SWAP2: begin
        st_we    = 1'b1;
        st_waddr = fill_r[AW-1:0];
        st_wdata = elem_r;
        fill_nxt = fill_r + ONE_C;
        i_nxt    = ip1_w;
        if (i_r == hi_r) begin
          state_nxt = S_FINR;
        end else begin
          st_re     = 1'b1;
          st_raddr  = ip1_w[AW-1:0];
          state_nxt = S_SCAN;
        end
      end
      S_FINR: begin
        if (p_w == lo_r) begin
          state_nxt = S_PUSHR;
        end else begin
          st_re     = 1'b1;
          st_raddr  = p_w[AW-1:0];
          state_nxt = S_FIN1;
        end
      end
      S_FIN1: begin
        st_we     = 1'b1;
        st_waddr  = lo_r[AW-1:0];
        st_wdata  = st_rdata;
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        st_we     = 1'b1;
        st_waddr  = p_w[AW-1:0];
        st_wdata  = pivot_r;
        state_nxt = S_PUSHR;
      end
      S_PUSHR: begin
        if ((pp1_w < hi_r) && (sp_r < CAP_C)) begin
          sk_we    = 1'b1;
          sk_waddr = sp_r[AW-1:0];
          sk_wdata = {pp1_w[AW-1:0], hi_r[AW-1:0]};
          sp_nxt   = sp_r + ONE_C;
        end
        state_nxt = S_PUSHL;
      end
      S_PUSHL: begin
        if ((p_w > (lo_r + ONE_C)) && (sp_r < CAP_C)) begin
          sk_we    = 1'b1;
          sk_waddr = sp_r[AW-1:0];
          sk_wdata = {lo_r[AW-1:0], pm1_w[AW-1:0]};
          sp_nxt   = sp_r + ONE_C;
        end
        state_nxt = S_POP;
      end
      S_EMIT: begin
        if (k_r < count_r) begin
          st_re     = 1'b1;
          st_raddr  = k_r[AW-1:0];
          valid_nxt = 1'b1;
          final_nxt = ((k_r + ONE_C) == count_r);
          drop_nxt  = ovf_r;
          k_nxt     = k_r + ONE_C;
        end else begin
          count_nxt = '0;
          sp_nxt    = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      sp_r    <= '0;
      ovf_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      sp_r    <= sp_nxt;
      ovf_r   <= ovf_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    final_r <= final_nxt;
    drop_r  <= drop_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    i_r     <= i_nxt;
    fill_r  <= fill_nxt;
    k_r     <= k_nxt;
    pivot_r <= pivot_nxt;
    elem_r  <= elem_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = valid_r;
  assign out_sorted_value = $signed(st_rdata);
  assign out_final_res    = valid_r & final_r;
  assign out_dropped      = valid_r & drop_r;

`ifndef SYNTHESIS
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside a sort");

  a_stack_room: assert property (@(posedge clk) disable iff (!rst_n)
    sk_we |-> (sp_r < CAP_C))
    else $error("range stack overflow");

  a_scan_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> ((i_r <= hi_r) && (fill_r <= i_r) && (lo_r < fill_r)))
    else $error("partition indices out of range");

  a_final_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_final_res) |=> !out_valid)
    else $error("result after final word");
`endif

endmodule
